@@ rtl/alu_pkg.sv @@
package alu_pkg;

	localparam int WORD_W = 32;
	localparam int SHAMT_W = 5;
	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_W - 1);

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_AND = 4'd1;
	localparam logic [3:0] OP_OR  = 4'd2;
	localparam logic [3:0] OP_XOR = 4'd3;
	localparam logic [3:0] OP_SHR = 4'd4;
	localparam logic [3:0] OP_SHL = 4'd5;
	localparam logic [3:0] OP_NOT = 4'd6;
	localparam logic [3:0] OP_SUB = 4'd7;
	localparam logic [3:0] OP_CMP = 4'd8;
	localparam logic [3:0] OP_MUL = 4'd9;
	localparam logic [3:0] OP_ROL = 4'd10;
	localparam logic [3:0] OP_ROR = 4'd11;
	localparam logic [3:0] OP_DIV = 4'd12;
	localparam logic [3:0] OP_MOD = 4'd13;

	typedef struct packed {
		logic [3:0]        operation;
		logic [WORD_W-1:0] operand_a;
		logic [WORD_W-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_word;
		logic              zero_flag;
		logic              negative_flag;
		logic              overflow_flag;
		logic              divide_fault;
		logic              bad_operation;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_go;
	} sts_t;

endpackage

@@ rtl/alu32_with_flags.sv @@
// 32-bit alu with held zero, negative and overflow flags.
// request channel: req_valid / req_ready carry req (operation, operand_a,
// operand_b); a request is taken when both are high at a clock edge.
// response channel: rsp_valid / rsp_ready carry rsp (result word, the held
// flags after this operation, divide fault and bad operation marks).
// one request is worked on at a time. req_ready is high whenever the
// controller is idle, even while a finished response still waits in the
// output register.
// a taken request is registered and passes the decode state; its response
// is loaded in the done state. div and mod with a nonzero divisor pass the
// divide state in between: the restoring divider produces one quotient bit
// per cycle, 32 in all. a new request is taken only after the done state.
// division by zero and unknown codes return 0 with a fault or bad mark and
// keep the held flags as they were.
// if the receiver stalls, the response holds in the output register; a next
// request is taken and computed, then waits until the output register frees.
// reset clears the controller, the response valid and the held flags.
module alu32_with_flags (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  alu_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output alu_pkg::rsp_t rsp
);

	alu_pkg::cmd_t cmd;
	alu_pkg::sts_t sts;

	alu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	alu_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

@@ rtl/alu_ctrl.sv @@
module alu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  alu_pkg::sts_t sts,
	output alu_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DECODE = 2'd1;
	localparam logic [1:0] ST_DIV    = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0]                state_q;
	logic [alu_pkg::CNT_W-1:0] cnt_q;
	logic                      rsp_valid_q;
	logic                      accept;
	logic                      out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd.load     = accept;
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					cnt_q <= '0;
					state_q <= sts.div_go ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == alu_pkg::DIV_LAST) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/alu_dp.sv @@
module alu_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  alu_pkg::req_t req,
	input  alu_pkg::cmd_t cmd,
	output alu_pkg::sts_t sts,
	output alu_pkg::rsp_t rsp
);

	localparam int W = alu_pkg::WORD_W;

	logic [3:0]   op_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [2:0]   held_q;
	alu_pkg::rsp_t rsp_q;

	logic [W:0]     shifted;
	logic [W:0]     trial;
	logic           b_zero;
	logic [W-1:0]   r;
	logic           v;
	logic           fault;
	logic           bad;
	logic [2*W-1:0] rol_w;
	logic [2*W-1:0] ror_w;
	logic [W-1:0]   sum;
	logic [W-1:0]   diff;
	logic [W-1:0]   prod;
	logic [alu_pkg::SHAMT_W-1:0] shamt;
	logic [2:0]     flags_next;

	assign b_zero = (b_q == '0);
	assign sts.div_go = ((op_q == alu_pkg::OP_DIV) || (op_q == alu_pkg::OP_MOD)) && !b_zero;

	// restoring division, one quotient bit a cycle
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, b_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.operation;
			a_q   <= req.operand_a;
			b_q   <= req.operand_b;
			rem_q <= '0;
			quo_q <= req.operand_a;
		end else if (cmd.div_step) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign shamt = b_q[alu_pkg::SHAMT_W-1:0];
	assign rol_w = {a_q, a_q} << shamt;
	assign ror_w = {a_q, a_q} >> shamt;
	assign sum   = a_q + b_q;
	assign diff  = a_q - b_q;
	assign prod  = a_q * b_q;

	always_comb begin
		r     = '0;
		v     = 1'b0;
		fault = 1'b0;
		bad   = 1'b0;
		unique case (op_q)
			alu_pkg::OP_ADD: begin
				r = sum;
				v = ~(a_q[W-1] ^ b_q[W-1]) & (a_q[W-1] ^ sum[W-1]);
			end
			alu_pkg::OP_AND: r = a_q & b_q;
			alu_pkg::OP_OR:  r = a_q | b_q;
			alu_pkg::OP_XOR: r = a_q ^ b_q;
			alu_pkg::OP_SHR: r = a_q >> shamt;
			alu_pkg::OP_SHL: r = a_q << shamt;
			alu_pkg::OP_NOT: r = ~a_q;
			alu_pkg::OP_SUB, alu_pkg::OP_CMP: begin
				r = diff;
				v = (a_q[W-1] ^ b_q[W-1]) & (a_q[W-1] ^ diff[W-1]);
			end
			alu_pkg::OP_MUL: r = prod;
			alu_pkg::OP_ROL: r = rol_w[2*W-1:W];
			alu_pkg::OP_ROR: r = ror_w[W-1:0];
			alu_pkg::OP_DIV: begin
				if (b_zero) fault = 1'b1;
				else r = quo_q;
			end
			alu_pkg::OP_MOD: begin
				if (b_zero) fault = 1'b1;
				else r = rem_q;
			end
			default: bad = 1'b1;
		endcase
	end

	// held flags: bit 0 zero, bit 1 negative, bit 2 overflow
	assign flags_next = (fault || bad) ? held_q : {v, r[W-1], (r == '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.out_load) begin
			held_q <= flags_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.result_word   <= r;
			rsp_q.zero_flag     <= flags_next[0];
			rsp_q.negative_flag <= flags_next[1];
			rsp_q.overflow_flag <= flags_next[2];
			rsp_q.divide_fault  <= fault;
			rsp_q.bad_operation <= bad;
		end
	end

	assign rsp = rsp_q;

endmodule

@@ rtl/alu_chk.sv @@
module alu_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input alu_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input alu_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_marks_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.divide_fault && rsp.bad_operation))
		else $error("fault and bad operation both set");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.divide_fault || rsp.bad_operation) |-> rsp.result_word == '0)
		else $error("nonzero result on fault or bad operation");

	a_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.divide_fault && !rsp.bad_operation |->
			(rsp.zero_flag == (rsp.result_word == '0)) &&
			(rsp.negative_flag == rsp.result_word[alu_pkg::WORD_W-1]))
		else $error("flags do not match result");

endmodule

bind alu32_with_flags alu_chk u_alu_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

@@ test/tb_alu32_with_flags.sv @@
`timescale 1ns / 1ps

class alu_checker;
	alu_pkg::rsp_t expected_results[$];
	logic held_zero;
	logic held_negative;
	logic held_overflow;
	int errors;

	function new();
		held_zero = 1'b0;
		held_negative = 1'b0;
		held_overflow = 1'b0;
		errors = 0;
	endfunction

	function alu_pkg::rsp_t alu_compute(alu_pkg::req_t r);
		logic [alu_pkg::WORD_W-1:0] a;
		logic [alu_pkg::WORD_W-1:0] b;
		logic [alu_pkg::WORD_W-1:0] res;
		logic [alu_pkg::SHAMT_W-1:0] sh;
		logic ovf;
		logic fault;
		logic bad;
		alu_pkg::rsp_t e;
		a = r.operand_a;
		b = r.operand_b;
		sh = b[alu_pkg::SHAMT_W-1:0];
		res = '0;
		ovf = 1'b0;
		fault = 1'b0;
		bad = 1'b0;
		case (r.operation)
			alu_pkg::OP_ADD: begin
				res = a + b;
				ovf = ~(a[31] ^ b[31]) & (a[31] ^ res[31]);
			end
			alu_pkg::OP_AND: res = a & b;
			alu_pkg::OP_OR: res = a | b;
			alu_pkg::OP_XOR: res = a ^ b;
			alu_pkg::OP_SHR: res = a >> sh;
			alu_pkg::OP_SHL: res = a << sh;
			alu_pkg::OP_NOT: res = ~a;
			alu_pkg::OP_SUB, alu_pkg::OP_CMP: begin
				res = a - b;
				ovf = (a[31] ^ b[31]) & (a[31] ^ res[31]);
			end
			alu_pkg::OP_MUL: res = a * b;
			alu_pkg::OP_ROL:
				res = (sh == 0) ? a : ((a << sh) | (a >> (alu_pkg::WORD_W - sh)));
			alu_pkg::OP_ROR:
				res = (sh == 0) ? a : ((a >> sh) | (a << (alu_pkg::WORD_W - sh)));
			alu_pkg::OP_DIV: begin
				if (b == 0) fault = 1'b1;
				else res = a / b;
			end
			alu_pkg::OP_MOD: begin
				if (b == 0) fault = 1'b1;
				else res = a % b;
			end
			default: bad = 1'b1;
		endcase
		if (fault || bad) begin
			res = '0;
		end else begin
			// a good result replaces all three held flags
			held_zero = (res == 0);
			held_negative = res[31];
			held_overflow = ovf;
		end
		e.result_word = res;
		e.zero_flag = held_zero;
		e.negative_flag = held_negative;
		e.overflow_flag = held_overflow;
		e.divide_fault = fault;
		e.bad_operation = bad;
		return e;
	endfunction

	function void note_request(alu_pkg::req_t r);
		expected_results.push_back(alu_compute(r));
	endfunction

	function void field_mismatch(string name, logic [alu_pkg::WORD_W-1:0] e,
		logic [alu_pkg::WORD_W-1:0] g);
		if (e !== g) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, e, g);
			errors++;
		end
	endfunction

	function void check_response(alu_pkg::rsp_t got);
		alu_pkg::rsp_t e;
		if (expected_results.size() == 0) begin
			$display("%0t: response with no request outstanding, actual %h", $time, got);
			errors++;
			return;
		end
		e = expected_results.pop_front();
		field_mismatch("result_word", e.result_word, got.result_word);
		field_mismatch("zero_flag", e.zero_flag, got.zero_flag);
		field_mismatch("negative_flag", e.negative_flag, got.negative_flag);
		field_mismatch("overflow_flag", e.overflow_flag, got.overflow_flag);
		field_mismatch("divide_fault", e.divide_fault, got.divide_fault);
		field_mismatch("bad_operation", e.bad_operation, got.bad_operation);
	endfunction

	function int pending();
		return expected_results.size();
	endfunction
endclass

module tb_alu32_with_flags;
	localparam int IDLE_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1150;
	localparam int LONG_HOLD = 400;
	// codes with no operation behind them
	localparam logic [3:0] OP_SPARE0 = 4'd14;
	localparam logic [3:0] OP_SPARE1 = 4'd15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	alu_pkg::req_t req = '0;
	logic rsp_ready = 1'b0;
	logic req_ready;
	logic rsp_valid;
	alu_pkg::rsp_t rsp;

	alu_checker board = new();
	bit hold_rsp = 1'b0;
	int idle_cycles = 0;

	alu32_with_flags dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int idle_gap();
		if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [alu_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'h7FFF_FFFF;
			5: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(input logic [3:0] op, input logic [alu_pkg::WORD_W-1:0] a,
		input logic [alu_pkg::WORD_W-1:0] b, input int gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{op, a, b};
		do @(posedge clk); while (!req_ready);
	endtask

	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) board.note_request(req);
		if (arst_n && rsp_valid && rsp_ready) board.check_response(rsp);
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no request or response moved for %0d cycles", $time, IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat (idle_gap() + 1) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	initial begin
		int gap;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// overflow and wrap corners of add
		send_request(alu_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, idle_gap());
		send_request(alu_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0000_0001, idle_gap());
		send_request(alu_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, idle_gap());
		send_request(alu_pkg::OP_AND, 32'hFFFF_FFFF, 32'hA5A5_5A5A, idle_gap());
		send_request(alu_pkg::OP_OR, 32'h0000_0000, 32'h0000_0000, idle_gap());
		send_request(alu_pkg::OP_XOR, 32'hFFFF_FFFF, 32'h0F0F_F0F0, idle_gap());
		send_request(alu_pkg::OP_SHR, 32'h8000_0000, 32'h0000_001F, idle_gap());
		send_request(alu_pkg::OP_SHL, 32'h0000_0001, 32'h0000_001F, idle_gap());
		// shift amount whose low five bits are zero
		send_request(alu_pkg::OP_SHR, 32'hDEAD_BEEF, 32'hFFFF_FFE0, idle_gap());
		send_request(alu_pkg::OP_NOT, 32'h0000_0000, 32'hFFFF_FFFF, idle_gap());
		send_request(alu_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001, idle_gap());
		// divide by zero keeps the overflow left by the sub
		send_request(alu_pkg::OP_DIV, 32'h1234_5678, 32'h0000_0000, idle_gap());
		send_request(alu_pkg::OP_CMP, 32'h5555_5555, 32'h5555_5555, idle_gap());
		send_request(alu_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, idle_gap());
		send_request(alu_pkg::OP_ROL, 32'h8000_0001, 32'h0000_0000, idle_gap());
		send_request(alu_pkg::OP_ROL, 32'h8000_0001, 32'h0000_0021, idle_gap());
		send_request(alu_pkg::OP_ROR, 32'hC000_0003, 32'hFFFF_FFE0, idle_gap());
		send_request(alu_pkg::OP_ROR, 32'h0000_0001, 32'h0000_001F, idle_gap());
		send_request(alu_pkg::OP_NOT, 32'h7FFF_FFFF, 32'h0000_0000, idle_gap());
		send_request(alu_pkg::OP_MOD, 32'hFFFF_FFFF, 32'h0000_0000, idle_gap());
		send_request(alu_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h0000_0001, idle_gap());
		send_request(alu_pkg::OP_MOD, 32'h0000_0007, 32'h0000_0003, idle_gap());
		send_request(OP_SPARE0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, idle_gap());
		send_request(OP_SPARE1, 32'h0000_0000, 32'h0000_0000, idle_gap());
		send_request(alu_pkg::OP_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF, idle_gap());

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// back-to-back bursts; each long receiver hold-off lands inside one
			gap = ((n % 250) < 50) ? 0 : idle_gap();
			if (n == 260 || n == 760) hold_rsp = 1'b1;
			send_request(4'($urandom_range(0, 15)), pick_word(), pick_word(), gap);
		end
		req_valid <= 1'b0;
		// let the monitor note the last request first
		@(posedge clk);

		while (board.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

@@ files.f @@
rtl/alu_pkg.sv
rtl/alu_ctrl.sv
rtl/alu_dp.sv
rtl/alu32_with_flags.sv
rtl/alu_chk.sv
test/tb_alu32_with_flags.sv
